// ===== design/sst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared item types, result codes and command and status groups of the stream
// id slot table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam logic [31:0] HASH_MUL = 32'd2654435761;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_INVALID  = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef struct packed {
		logic        op;
		logic [31:0] flow_id;
	} req_item_t;

	typedef struct packed {
		logic [5:0] slot_index;
		status_t    status;
	} rsp_item_t;

	typedef struct packed {
		logic    accept;
		logic    clr_start;
		logic    clr_write;
		logic    mod_step;
		logic    rd_home;
		logic    probe_next;
		logic    insert;
		logic    out_load;
		logic    out_from_stash;
		logic    stash;
		status_t res_code;
	} sst_cmd_t;

	typedef struct packed {
		logic req_op;
		logic req_id_zero;
		logic match;
		logic empty;
		logic at_limit;
		logic exhausted;
		logic clr_last;
		logic mod_last;
		logic out_free;
	} sst_stat_t;

endpackage

// ===== design/sst_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_datapath
// Slot memory, hash and home slot unit, probe address, occupancy count and
// the output register of the stream id slot table.
// ----------------------------------------------------------------------------
module sst_datapath import sst_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rsp_item_t rsp,
	input  sst_cmd_t  cmd,
	output sst_stat_t st
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SH = 32 + AW;
	localparam logic [CW-1:0] LIMIT = CW'((3 * SLOTS) / 4);
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [32:0] RECIP =
		33'(((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

	logic [31:0]   mem [SLOTS];
	logic [31:0]   rd_q;
	logic [31:0]   id_q;
	logic [31:0]   hash_q;
	logic [31:0]   product;
	logic [64:0]   recip_prod;
	logic [31:0]   quot_q;
	logic [31:0]   rem_full;
	logic [AW-1:0] rem_q;
	logic          mod_phase_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] pc_q;
	logic [AW-1:0] home;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] addr_next;
	logic [CW-1:0] occ_q;
	logic [31:0]   addr_ext;
	rsp_item_t     res_new;
	rsp_item_t     stash_q;
	rsp_item_t     rsp_q;
	logic          rsp_valid_q;

	assign product    = req.flow_id * HASH_MUL;
	assign recip_prod = 65'(hash_q) * 65'(RECIP);
	assign rem_full   = hash_q - quot_q * 32'(SLOTS);
	assign home       = POW2 ? hash_q[AW-1:0] : rem_q;
	assign rd_addr    = cmd.rd_home ? home : addr_q;
	assign addr_next  = (addr_q == LAST) ? '0 : addr_q + 1'b1;
	assign addr_ext   = 32'(addr_q);

	always_comb begin
		res_new.status = cmd.res_code;
		if (cmd.res_code == ST_FOUND || cmd.res_code == ST_INSERTED) begin
			res_new.slot_index = addr_ext[5:0];
		end else begin
			res_new.slot_index = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_write) begin
			mem[addr_q] <= '0;
		end else if (cmd.insert) begin
			mem[addr_q] <= id_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			id_q        <= req.flow_id;
			hash_q      <= product;
			mod_phase_q <= 1'b0;
		end else if (cmd.mod_step) begin
			if (!mod_phase_q) begin
				quot_q <= 32'(recip_prod >> SH);
			end else begin
				rem_q <= rem_full[AW-1:0];
			end
			mod_phase_q <= 1'b1;
		end
		if (cmd.stash) begin
			stash_q <= res_new;
		end
		if (cmd.out_load) begin
			rsp_q <= cmd.out_from_stash ? stash_q : res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			pc_q        <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				addr_q <= '0;
				occ_q  <= '0;
			end else if (cmd.clr_write) begin
				addr_q <= addr_next;
			end else if (cmd.rd_home) begin
				addr_q <= home;
				pc_q   <= '0;
			end else if (cmd.probe_next) begin
				addr_q <= addr_next;
				pc_q   <= pc_q + 1'b1;
			end
			if (cmd.insert) begin
				occ_q <= occ_q + 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign st.req_op      = req.op;
	assign st.req_id_zero = req.flow_id == '0;
	assign st.match       = rd_q == id_q;
	assign st.empty       = rd_q == '0;
	assign st.at_limit    = occ_q >= LIMIT;
	assign st.exhausted   = pc_q == LAST;
	assign st.clr_last    = addr_q == LAST;
	assign st.mod_last    = mod_phase_q;
	assign st.out_free    = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("output register loaded while a result is still held");

	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (st.empty && !st.at_limit && !st.match))
		else $error("insert into an occupied slot or past the load limit");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !cmd.clr_start) |=> occ_q == CW'($past(occ_q) + 1'b1))
		else $error("occupancy did not rise after an insert");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= LIMIT)
		else $error("occupancy beyond the load limit");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_FOUND || rsp.status == ST_INSERTED
			|| rsp.slot_index == '0))
		else $error("nonzero slot index on a result without a slot");

endmodule

// ===== design/sst_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_controller
// Sequencer of the stream id slot table: clearing sweep, home slot reduction,
// probe loop and result hand-off.
// ----------------------------------------------------------------------------
module sst_controller import sst_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  sst_stat_t st,
	output sst_cmd_t  cmd
);

	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_MOD   = 7'b0000100,
		S_HOME  = 7'b0001000,
		S_READ  = 7'b0010000,
		S_CMP   = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   clr_cmd_q, clr_cmd_d;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d   = state_q;
		clr_cmd_d = clr_cmd_q;
		cmd       = '0;
		cmd.res_code = ST_FULL;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (st.clr_last) begin
					if (clr_cmd_q) begin
						cmd.res_code = ST_CLEARED;
						if (st.out_free) begin
							cmd.out_load = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.stash = 1'b1;
							state_d = S_RESP;
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					priority if (st.req_op == OP_CLEAR) begin
						cmd.clr_start = 1'b1;
						clr_cmd_d = 1'b1;
						state_d = S_CLEAR;
					end else if (st.req_id_zero) begin
						cmd.res_code = ST_INVALID;
						if (st.out_free) begin
							cmd.out_load = 1'b1;
						end else begin
							cmd.stash = 1'b1;
							state_d = S_RESP;
						end
					end else begin
						state_d = POW2 ? S_HOME : S_MOD;
					end
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_last) begin
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.rd_home = 1'b1;
				state_d = S_CMP;
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				priority if (st.match) begin
					cmd.res_code = ST_FOUND;
				end else if (st.empty) begin
					if (st.at_limit) begin
						cmd.res_code = ST_FULL;
					end else begin
						cmd.res_code = ST_INSERTED;
						cmd.insert = 1'b1;
					end
				end else begin
					cmd.res_code = ST_FULL;
				end
				if (st.match || st.empty || st.exhausted) begin
					if (st.out_free) begin
						cmd.out_load = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.stash = 1'b1;
						state_d = S_RESP;
					end
				end else begin
					cmd.probe_next = 1'b1;
					state_d = S_READ;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_from_stash = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (state_d == S_IDLE) begin
			clr_cmd_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cmd_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cmd_q <= clr_cmd_d;
		end
	end

endmodule

// ===== design/stream_id_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_id_slot_table
// Open-addressed table with linear probing that maps a nonzero 32-bit stream
// id to a slot index and reports found, inserted, full, invalid or cleared.
// ----------------------------------------------------------------------------
// Requests arrive on req (op, flow_id) under req_valid and req_stall; one
// result item (slot_index, status) leaves on rsp under rsp_valid and
// rsp_stall. Every request gives exactly one result.
// One item is in work at a time. A lookup or insert reads the home slot
// and compares it, and each further slot probed adds another registered
// read of the slot memory followed by a compare. When SLOTS is not a power
// of two the home slot is first reduced by a reciprocal multiplication in
// a quotient step and a remainder step. Id zero is answered directly from
// the idle state. A clear sweeps the slot memory one entry a cycle.
// The result is loaded into the output register as the item ends; while
// the receiver stalls it is held, and the following item is still accepted
// and worked on until its own result is ready, where it waits.
// After reset the block sweeps the slot memory to empty and holds req_stall
// high meanwhile; the occupancy count starts at zero.
// ----------------------------------------------------------------------------
module stream_id_slot_table import sst_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	sst_cmd_t  cmd;
	sst_stat_t st;

	sst_controller #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.st       (st),
		.cmd      (cmd)
	);

	sst_datapath #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

// ===== sim/tb_stream_id_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_id_slot_table
// Self-checking bench for the stream id slot table. A short directed run
// covers id zero, clears and probe chains that collide and wrap round the
// table. Random requests then fill the table up to its load limit and clear
// it again, with clustered home slots to force long probe chains. Idle and
// stall patterns on both sides change from phase to phase. A scoreboard class
// keeps its own copy of the table, predicts every result and checks each
// result item field by field in order.
// ----------------------------------------------------------------------------
module tb_stream_id_slot_table;
	import sst_pkg::*;

	localparam int SLOT_COUNT = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 200;

	class slot_table_scoreboard;
		logic [31:0] slot_ids [SLOT_COUNT];
		int unsigned occupancy;
		rsp_item_t expected_results[$];
		int unsigned mismatches;

		function new();
			foreach (slot_ids[i]) slot_ids[i] = '0;
			occupancy = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_request(req_item_t item);
			rsp_item_t res;
			logic [31:0] hash;
			logic [31:0] home;
			logic [31:0] probe;
			bit done;
			res.slot_index = '0;
			res.status = ST_FULL;
			if (item.op == OP_CLEAR) begin
				foreach (slot_ids[i]) slot_ids[i] = '0;
				occupancy = 0;
				res.status = ST_CLEARED;
			end else if (item.flow_id == '0) begin
				res.status = ST_INVALID;
			end else begin
				hash = item.flow_id * HASH_MUL;
				home = hash % SLOT_COUNT;
				done = 1'b0;
				for (int i = 0; i < SLOT_COUNT && !done; i++) begin
					probe = (home + i) % SLOT_COUNT;
					if (slot_ids[probe] == item.flow_id) begin
						res.slot_index = probe[5:0];
						res.status = ST_FOUND;
						done = 1'b1;
					end else if (slot_ids[probe] == '0) begin
						done = 1'b1;
						if ((occupancy + 1) * 4 <= SLOT_COUNT * 3) begin
							slot_ids[probe] = item.flow_id;
							occupancy++;
							res.slot_index = probe[5:0];
							res.status = ST_INSERTED;
						end
					end
				end
			end
			expected_results.push_back(res);
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t want;
			if (expected_results.size() == 0) begin
				$error("result item with none expected: slot_index %0d status %0d",
					got.slot_index, got.status);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (got.slot_index !== want.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;

	slot_table_scoreboard slot_check = new();
	logic [31:0] hash_inverse;
	logic [31:0] known_ids[$];
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;

	stream_id_slot_table #(
		.SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) slot_check.note_request(req);
			if (rsp_valid && !rsp_stall) slot_check.check_result(rsp);
		end
	end

	// The long hold-off is counted here so that the sender keeps offering items meanwhile.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_requests != holds_served) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin
		#20ms;
		$display("FAIL stream_id_slot_table");
		$finish;
	end

	// Builds a nonzero id whose hash has the given home slot.
	function automatic logic [31:0] id_at_home(input logic [5:0] home);
		logic [25:0] upper;
		upper = 26'($urandom_range(1, 32'h03FF_FFFF));
		return {upper, home} * hash_inverse;
	endfunction

	task automatic send_request(input logic op, input logic [31:0] id);
		req_item_t item;
		item.op = op;
		item.flow_id = id;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (slot_check.pending() != 0) @(posedge clk);
	endtask

	task automatic send_mixed(input int count);
		int unsigned pick;
		logic [31:0] id;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 1) begin
				send_request(OP_CLEAR, $urandom());
			end else if (pick < 4) begin
				send_request(OP_LOOKUP, '0);
			end else if (pick < 40 && known_ids.size() != 0) begin
				send_request(OP_LOOKUP, known_ids[$urandom_range(0, known_ids.size() - 1)]);
			end else begin
				if (pick < 75) id = id_at_home(6'($urandom_range(60, 67)));
				else id = $urandom();
				send_request(OP_LOOKUP, id);
				if (id != '0) known_ids.push_back(id);
				if (known_ids.size() > 96) void'(known_ids.pop_front());
			end
		end
	endtask

	initial begin
		logic [31:0] chain [5];
		hash_inverse = HASH_MUL;
		repeat (5) hash_inverse = hash_inverse * (32'd2 - HASH_MUL * hash_inverse);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_request(OP_LOOKUP, '0);
		send_request(OP_CLEAR, 32'hFFFF_FFFF);
		send_request(OP_LOOKUP, 32'd1);
		send_request(OP_LOOKUP, 32'd1);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF);
		send_request(OP_LOOKUP, 32'h8000_0000);
		// Two ids share the home slot of id 1; three more pile up at the last slot and wrap.
		chain[0] = id_at_home(6'd49);
		chain[1] = id_at_home(6'd49);
		chain[2] = id_at_home(6'd63);
		chain[3] = id_at_home(6'd63);
		chain[4] = id_at_home(6'd63);
		foreach (chain[i]) send_request(OP_LOOKUP, chain[i]);
		foreach (chain[i]) send_request(OP_LOOKUP, chain[i]);
		send_request(OP_CLEAR, '0);
		send_request(OP_LOOKUP, chain[4]);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF);
		wait_for_results();

		hold_requests = hold_requests + 1;
		send_mixed(40);
		send_mixed(280);
		wait_for_results();

		send_idle_pct = 69;
		send_mixed(320);
		wait_for_results();

		send_idle_pct = 0;
		stall_pct = 69;
		send_mixed(320);
		wait_for_results();

		send_idle_pct = 34;
		stall_pct = 34;
		send_mixed(320);
		wait_for_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (slot_check.mismatches == 0 && slot_check.pending() == 0) begin
			$display("PASS stream_id_slot_table");
		end else begin
			$display("FAIL stream_id_slot_table");
		end
		$finish;
	end

endmodule
